/* rtl/core/rtlp_pkg.sv */
// ----------------------------------------------------------------------------
// Routing table package
// Shared widths, codes, beat types and helper functions for the
// longest-prefix-match routing table and its cells.
// ----------------------------------------------------------------------------
package rtlp_pkg;

  // Table geometry.
  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = $clog2(TableDepth);
  localparam int unsigned PortBits   = 8;
  localparam int unsigned AddrW      = 32;
  localparam int unsigned LenW       = 6;
  localparam int unsigned MetricW    = 5;

  localparam logic [LenW-1:0]    FullLen   = LenW'(AddrW);
  localparam logic [MetricW-1:0] MaxMetric = MetricW'(16);

  // Command codes.
  localparam logic [1:0] OP_INSERT    = 2'd0;
  localparam logic [1:0] OP_DELETE    = 2'd1;
  localparam logic [1:0] OP_LOOKUP    = 2'd2;
  localparam logic [1:0] OP_DV_UPDATE = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // Command beat.
  typedef struct packed {
    logic [1:0]          opcode;
    logic [AddrW-1:0]    address;
    logic [LenW-1:0]     prefix_len;
    logic [AddrW-1:0]    prefix_mask;
    logic [AddrW-1:0]    next_hop;
    logic [PortBits-1:0] port;
    logic [MetricW-1:0]  metric;
  } in_beat_t;

  // Result beat.
  typedef struct packed {
    logic                hit;
    logic [AddrW-1:0]    out_next_hop;
    logic [PortBits-1:0] out_port;
    logic [1:0]          status;
  } out_beat_t;

  // Search key seen by every cell.
  typedef struct packed {
    logic [AddrW-1:0] addr;
    logic [AddrW-1:0] prefix;
    logic [LenW-1:0]  len;
  } search_t;

  // Token handed from cell to cell during a scan.
  typedef struct packed {
    logic                active;
    logic                exact_hit;
    logic [IdxW-1:0]     exact_idx;
    logic [MetricW-1:0]  exact_metric;
    logic                free_hit;
    logic [IdxW-1:0]     free_idx;
    logic                best_hit;
    logic [LenW-1:0]     best_len;
    logic [AddrW-1:0]    best_nh;
    logic [PortBits-1:0] best_port;
  } tok_t;

  // Table write broadcast to all cells.
  typedef struct packed {
    logic                en;
    logic [IdxW-1:0]     idx;
    logic                set_valid;
    logic                clr_valid;
    logic                wr_route;
    logic                wr_metric;
    logic [AddrW-1:0]    prefix;
    logic [LenW-1:0]     len;
    logic [AddrW-1:0]    nh;
    logic [PortBits-1:0] port;
    logic [MetricW-1:0]  metric;
  } wr_t;

  // Network mask with the top len bits set; len is at most 32.
  function automatic logic [AddrW-1:0] len_mask(input logic [LenW-1:0] len);
    return ~({AddrW{1'b1}} >> len);
  endfunction

  // Count of leading ones from the most significant bit.
  function automatic logic [LenW-1:0] lead_ones(input logic [AddrW-1:0] m);
    logic [LenW-1:0] n;
    n = FullLen;
    // The highest zero bit is seen last and sets the count.
    for (int i = 0; i < AddrW; i++) begin
      if (!m[i]) begin
        n = LenW'(AddrW - 1 - i);
      end
    end
    return n;
  endfunction

endpackage

/* rtl/core/rtlp_cell.sv */
// ----------------------------------------------------------------------------
// Routing table cell
// Holds one table entry, folds its own comparison into the scan token and
// hands the token to the next cell through its token register.
// ----------------------------------------------------------------------------
module rtlp_cell
  import rtlp_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [IdxW-1:0] cell_idx_i,
  input  search_t         srch_i,
  input  wr_t             wr_i,
  input  tok_t            tok_i,
  output tok_t            tok_o
);

  logic                valid_q;
  logic [AddrW-1:0]    prefix_q;
  logic [LenW-1:0]     len_q;
  logic [AddrW-1:0]    nh_q;
  logic [PortBits-1:0] port_q;
  logic [MetricW-1:0]  metric_q;

  logic exact_match;
  logic route_match;
  logic wr_sel;
  tok_t tok_d;
  tok_t tok_q;

  assign wr_sel = wr_i.en && (wr_i.idx == cell_idx_i);

  // Valid bit of the entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (wr_sel) begin
      if (wr_i.set_valid) begin
        valid_q <= 1'b1;
      end else if (wr_i.clr_valid) begin
        valid_q <= 1'b0;
      end
    end
  end

  // Entry payload, meaningful only while valid.
  always_ff @(posedge clk_i) begin
    if (wr_sel && wr_i.set_valid) begin
      prefix_q <= wr_i.prefix;
      len_q    <= wr_i.len;
    end
    if (wr_sel && wr_i.wr_route) begin
      nh_q   <= wr_i.nh;
      port_q <= wr_i.port;
    end
    if (wr_sel && wr_i.wr_metric) begin
      metric_q <= wr_i.metric;
    end
  end

  // Comparisons against the broadcast key.
  assign exact_match = valid_q && (prefix_q == srch_i.prefix) && (len_q == srch_i.len);
  assign route_match = valid_q && ((srch_i.addr & len_mask(len_q)) == prefix_q);

  // Fold this entry into the token; the lowest index wins every tie.
  always_comb begin
    tok_d = tok_i;
    if (exact_match && !tok_i.exact_hit) begin
      tok_d.exact_hit    = 1'b1;
      tok_d.exact_idx    = cell_idx_i;
      tok_d.exact_metric = metric_q;
    end
    if (!valid_q && !tok_i.free_hit) begin
      tok_d.free_hit = 1'b1;
      tok_d.free_idx = cell_idx_i;
    end
    if (route_match && (!tok_i.best_hit || (len_q > tok_i.best_len))) begin
      tok_d.best_hit  = 1'b1;
      tok_d.best_len  = len_q;
      tok_d.best_nh   = nh_q;
      tok_d.best_port = port_q;
    end
  end

  // Token register toward the next cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

/* rtl/core/route_table_longest_prefix.sv */
// ----------------------------------------------------------------------------
// Longest-prefix-match routing table
// IPv4 route table built as a chain of entry cells. A command token walks the
// chain, collecting the exact match, the first free slot and the best route;
// the controller then writes the table and returns one result beat.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                  | Beat
//  --------+-----------+----------------------------+------------
//  in      | input     | in_valid_i / in_stall_o    | in_beat_t
//  out     | output    | out_valid_o / out_stall_i  | out_beat_t
//
// The command is registered into the key and the start pulse; the token then
// walks the chain one cell per cycle, is captured as the final token, and the
// result is loaded into the output register.
// Commands are taken one at a time; the next one is accepted while the
// previous result still waits in the output register.
// Reset empties the table at once; no clearing pass is needed.
// A stall on the output holds the finished command until its result can be loaded.
//
module route_table_longest_prefix
  import rtlp_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

  typedef struct packed {
    logic [1:0]          op;
    logic [AddrW-1:0]    addr;
    logic [AddrW-1:0]    prefix;
    logic [LenW-1:0]     len;
    logic [AddrW-1:0]    nh;
    logic [PortBits-1:0] port;
    logic [MetricW-1:0]  metric;
  } key_t;

  state_e state_q, state_d;
  key_t   key_q, key_d;
  logic   start_q;
  tok_t   fin_q;
  logic   in_accept;
  logic   out_load;
  logic   out_valid_q, out_valid_d;
  out_beat_t out_q;
  out_beat_t res;
  wr_t    wr_plan;
  wr_t    wr_bcast;
  search_t srch;

  logic [LenW-1:0]    len_sat;
  logic [LenW-1:0]    key_len;
  logic [LenW-1:0]    dv_metric;
  logic [MetricW-1:0] ins_metric;

  tok_t tok_chain [TableDepth+1];
  logic [TableDepth-1:0] tok_act;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);

  // Key preparation on acceptance.
  always_comb begin
    len_sat    = (in_data_i.prefix_len > FullLen) ? FullLen : in_data_i.prefix_len;
    key_len    = (in_data_i.opcode == OP_DV_UPDATE) ? lead_ones(in_data_i.prefix_mask)
                                                    : len_sat;
    dv_metric  = {1'b0, in_data_i.metric} + LenW'(1);
    ins_metric = (in_data_i.metric > MaxMetric) ? MaxMetric : in_data_i.metric;
    key_d.op     = in_data_i.opcode;
    key_d.addr   = in_data_i.address;
    key_d.len    = key_len;
    key_d.prefix = in_data_i.address & len_mask(key_len);
    key_d.nh     = in_data_i.next_hop;
    key_d.port   = in_data_i.port;
    if (in_data_i.opcode == OP_DV_UPDATE) begin
      key_d.metric = (dv_metric > {1'b0, MaxMetric}) ? MaxMetric : dv_metric[MetricW-1:0];
    end else begin
      key_d.metric = ins_metric;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      key_q <= key_d;
    end
  end

  // Scan start pulse into the first cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= 1'b0;
    end else begin
      start_q <= in_accept;
    end
  end

  always_comb begin
    tok_chain[0]        = '0;
    tok_chain[0].active = start_q;
  end

  assign srch.addr   = key_q.addr;
  assign srch.prefix = key_q.prefix;
  assign srch.len    = key_q.len;

  // The cell chain.
  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    rtlp_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IdxW'(g)),
      .srch_i     (srch),
      .wr_i       (wr_bcast),
      .tok_i      (tok_chain[g]),
      .tok_o      (tok_chain[g+1])
    );
    assign tok_act[g] = tok_chain[g+1].active;
  end

  // Final token capture.
  always_ff @(posedge clk_i) begin
    if (tok_chain[TableDepth].active) begin
      fin_q <= tok_chain[TableDepth];
    end
  end

  // Result and table write from the finished scan.
  always_comb begin
    res              = '0;
    res.status       = ST_OK;
    wr_plan          = '0;
    wr_plan.prefix   = key_q.prefix;
    wr_plan.len      = key_q.len;
    wr_plan.nh       = key_q.nh;
    wr_plan.port     = key_q.port;
    wr_plan.metric   = key_q.metric;
    unique case (key_q.op)
      OP_INSERT: begin
        if (fin_q.exact_hit) begin
          wr_plan.en       = 1'b1;
          wr_plan.idx      = fin_q.exact_idx;
          wr_plan.wr_route = 1'b1;
        end else if (fin_q.free_hit) begin
          wr_plan.en        = 1'b1;
          wr_plan.idx       = fin_q.free_idx;
          wr_plan.set_valid = 1'b1;
          wr_plan.wr_route  = 1'b1;
          wr_plan.wr_metric = 1'b1;
        end else begin
          res.status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (fin_q.exact_hit) begin
          wr_plan.en        = 1'b1;
          wr_plan.idx       = fin_q.exact_idx;
          wr_plan.clr_valid = 1'b1;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      OP_LOOKUP: begin
        if (fin_q.best_hit) begin
          res.hit          = 1'b1;
          res.out_next_hop = fin_q.best_nh;
          res.out_port     = fin_q.best_port;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      OP_DV_UPDATE: begin
        if (fin_q.exact_hit) begin
          // Replace only with a strictly better metric.
          if (key_q.metric < fin_q.exact_metric) begin
            wr_plan.en        = 1'b1;
            wr_plan.idx       = fin_q.exact_idx;
            wr_plan.wr_route  = 1'b1;
            wr_plan.wr_metric = 1'b1;
          end
        end else if (fin_q.free_hit) begin
          wr_plan.en        = 1'b1;
          wr_plan.idx       = fin_q.free_idx;
          wr_plan.set_valid = 1'b1;
          wr_plan.wr_route  = 1'b1;
          wr_plan.wr_metric = 1'b1;
        end else begin
          res.status = ST_FULL;
        end
      end
    endcase
  end

  // The table is written in the same cycle the result is loaded.
  always_comb begin
    wr_bcast    = wr_plan;
    wr_bcast.en = wr_plan.en && out_load;
  end

  // Command sequencing.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (tok_chain[TableDepth].active) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Output register.
  assign out_load = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // At most one scan token is in flight along the chain.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_act))
    else $error("more than one token in the cell chain");

  // A token leaves the chain only while a scan is running.
  a_token_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_chain[TableDepth].active |-> (state_q == S_SCAN))
    else $error("token left the chain outside a scan");

  // The scan start pulse follows an accepted command.
  a_start_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (start_q && (state_q == S_SCAN)))
    else $error("scan did not start after an accepted command");

  // A loaded result is presented in the next cycle.
  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_o)
    else $error("loaded result not presented");
`endif

endmodule
